>>> hw/rtl/alr_pkg.sv
`timescale 1ns / 1ps
// alr_pkg: shared widths, fixed-point constants and the controller/datapath
// command and status structs. No dependencies.
package alr_pkg;

	localparam int COORD_W         = 12;
	localparam int FRAC_BITS       = 8;
	localparam int SLOPE_FRAC_BITS = 16;
	localparam int PIX_W           = 6;
	localparam int COV_W           = 9;
	localparam int COV_FRAC        = 8;
	localparam int MAX_COLS        = 15;
	localparam int DIV_STEPS       = SLOPE_FRAC_BITS + 1;
	localparam int DIV_CNT_W       = $clog2(DIV_STEPS);

	// one strobe per datapath operation; sel_e2 and last qualify them
	typedef struct packed {
		logic load;
		logic orient;
		logic order;
		logic diff;
		logic div_step;
		logic grad;
		logic mul;
		logic sum;
		logic cov;
		logic step;
		logic emit_lo;
		logic emit_hi;
		logic sel_e2;
		logic last;
	} alr_cmd_t;

	typedef struct packed {
		logic out_free;
		logic cnt_zero;
	} alr_status_t;

endpackage

>>> hw/rtl/alr_ifs.sv
`timescale 1ns / 1ps
// alr_seg_if / alr_pix_if: valid/ready channels for segments and pixel words.
// Depends on alr_pkg.
interface alr_seg_if;
	logic                           valid;
	logic                           ready;
	logic [alr_pkg::COORD_W-1:0]    start_x;
	logic [alr_pkg::COORD_W-1:0]    start_y;
	logic [alr_pkg::COORD_W-1:0]    end_x;
	logic [alr_pkg::COORD_W-1:0]    end_y;

	modport source (output valid, output start_x, output start_y, output end_x,
		output end_y, input ready);
	modport sink (input valid, input start_x, input start_y, input end_x,
		input end_y, output ready);
endinterface

interface alr_pix_if;
	logic                               valid;
	logic                               ready;
	logic signed [alr_pkg::PIX_W-1:0]   pixel_x;
	logic signed [alr_pkg::PIX_W-1:0]   pixel_y;
	logic [alr_pkg::COV_W-1:0]          coverage;
	logic                               last;

	modport source (output valid, output pixel_x, output pixel_y, output coverage,
		output last, input ready);
	modport sink (input valid, input pixel_x, input pixel_y, input coverage,
		input last, output ready);
endinterface

>>> hw/rtl/alr_ctrl.sv
`timescale 1ns / 1ps
// alr_ctrl: sequencer for one segment - orient, divide, two endpoints, columns.
// Depends on alr_pkg.
module alr_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 seg_valid,
	output logic                 seg_ready,
	input  alr_pkg::alr_status_t status,
	output alr_pkg::alr_cmd_t    cmd
);

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_ORIENT  = 4'd1;
	localparam logic [3:0] ST_ORDER   = 4'd2;
	localparam logic [3:0] ST_DIFF    = 4'd3;
	localparam logic [3:0] ST_DIV     = 4'd4;
	localparam logic [3:0] ST_GRAD    = 4'd5;
	localparam logic [3:0] ST_MUL     = 4'd6;
	localparam logic [3:0] ST_SUM     = 4'd7;
	localparam logic [3:0] ST_COV     = 4'd8;
	localparam logic [3:0] ST_EMIT_LO = 4'd9;
	localparam logic [3:0] ST_EMIT_HI = 4'd10;
	localparam logic [3:0] ST_STEP    = 4'd11;

	localparam logic [1:0] PH_E1  = 2'd0;
	localparam logic [1:0] PH_E2  = 2'd1;
	localparam logic [1:0] PH_COL = 2'd2;

	localparam logic [alr_pkg::DIV_CNT_W-1:0] DIV_LAST =
		alr_pkg::DIV_CNT_W'(alr_pkg::DIV_STEPS - 1);

	logic [3:0]                    state_q, state_d;
	logic [1:0]                    phase_q, phase_d;
	logic [alr_pkg::DIV_CNT_W-1:0] div_cnt_q, div_cnt_d;

	always_comb begin
		state_d    = state_q;
		phase_d    = phase_q;
		div_cnt_d  = div_cnt_q;
		cmd        = '0;
		cmd.sel_e2 = (phase_q == PH_E2);
		seg_ready  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				seg_ready = 1'b1;
				if (seg_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_ORIENT;
				end
			end
			ST_ORIENT: begin
				cmd.orient = 1'b1;
				state_d    = ST_ORDER;
			end
			ST_ORDER: begin
				cmd.order = 1'b1;
				state_d   = ST_DIFF;
			end
			ST_DIFF: begin
				cmd.diff  = 1'b1;
				div_cnt_d = '0;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (div_cnt_q == DIV_LAST) begin
					state_d = ST_GRAD;
				end else begin
					div_cnt_d = div_cnt_q + 1'b1;
				end
			end
			ST_GRAD: begin
				cmd.grad = 1'b1;
				phase_d  = PH_E1;
				state_d  = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = ST_COV;
			end
			ST_COV: begin
				cmd.cov = 1'b1;
				state_d = ST_EMIT_LO;
			end
			ST_EMIT_LO: begin
				if (status.out_free) begin
					cmd.emit_lo = 1'b1;
					state_d     = ST_EMIT_HI;
				end
			end
			ST_EMIT_HI: begin
				if (status.out_free) begin
					cmd.emit_hi = 1'b1;
					cmd.last    = (phase_q != PH_E1) && status.cnt_zero;
					if (phase_q == PH_E1) begin
						phase_d = PH_E2;
						state_d = ST_MUL;
					end else if (status.cnt_zero) begin
						state_d = ST_IDLE;
					end else begin
						phase_d = PH_COL;
						state_d = ST_STEP;
					end
				end
			end
			ST_STEP: begin
				cmd.step = 1'b1;
				state_d  = ST_COV;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			phase_q   <= PH_E1;
			div_cnt_q <= '0;
		end else begin
			state_q   <= state_d;
			phase_q   <= phase_d;
			div_cnt_q <= div_cnt_d;
		end
	end

endmodule

>>> hw/rtl/alr_datapath.sv
`timescale 1ns / 1ps
// alr_datapath: endpoint registers, restoring divider, shared coverage
// multiplier, y accumulator and the output word register. Depends on alr_pkg.
module alr_datapath #(
	parameter int unsigned LIMIT = 15
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  alr_pkg::alr_cmd_t                  cmd,
	output alr_pkg::alr_status_t               status,
	input  logic [alr_pkg::COORD_W-1:0]        start_x,
	input  logic [alr_pkg::COORD_W-1:0]        start_y,
	input  logic [alr_pkg::COORD_W-1:0]        end_x,
	input  logic [alr_pkg::COORD_W-1:0]        end_y,
	output logic                               pix_valid,
	input  logic                               pix_ready,
	output logic signed [alr_pkg::PIX_W-1:0]   pixel_x,
	output logic signed [alr_pkg::PIX_W-1:0]   pixel_y,
	output logic [alr_pkg::COV_W-1:0]          coverage,
	output logic                               last
);

	localparam int CW   = alr_pkg::COORD_W;
	localparam int F    = alr_pkg::FRAC_BITS;
	localparam int S    = alr_pkg::SLOPE_FRAC_BITS;
	localparam int XW   = CW + 1 - F;          // pixel column
	localparam int DW   = F + 1;               // endpoint offset / x gap
	localparam int QW   = S + 1;               // quotient
	localparam int GW   = S + 2;               // signed gradient
	localparam int RW   = CW + 1;              // divider remainder
	localparam int SW   = S + 16;              // endpoint y sum
	localparam int YW   = SW - F;              // y with S fraction bits
	localparam int IW   = YW - S;              // integer part of y
	localparam int PW   = S + F + 1;           // coverage product
	localparam int SH   = S + F - alr_pkg::COV_FRAC;
	localparam int NW   = $clog2(LIMIT + 1);
	localparam int SPW  = ((XW > NW) ? XW : NW) + 2;
	localparam int HALF = 1 << (F - 1);
	localparam int ONE  = 1 << F;

	logic [CW-1:0]          x0_q, y0_q, x1_q, y1_q;
	logic                   steep_q;
	logic [CW-1:0]          dx_q;
	logic                   dy_neg_q;
	logic [RW-1:0]          rem_q;
	logic [QW-1:0]          quo_q;
	logic signed [GW-1:0]   grad_q;
	logic [XW-1:0]          xe1_q, xe2_q;
	logic signed [DW-1:0]   d1_q, d2_q;
	logic [DW-1:0]          xg1_q, xg2_q;
	logic signed [GW+DW-1:0] prod_q;
	logic signed [YW-1:0]   ycur_q, yacc_q;
	logic [XW-1:0]          xcur_q, col_q;
	logic [DW-1:0]          xg_q;
	logic [NW-1:0]          cnt_q;
	logic [PW-1:0]          p_q;
	logic                   out_valid_q;
	logic signed [alr_pkg::PIX_W-1:0] px_q, py_q;
	logic [alr_pkg::COV_W-1:0] cov_q;
	logic                   last_q;

	// orientation
	logic signed [CW:0]     odx_c, ody_c, adx_c, ady_c;
	logic                   steep_c;
	// differences and endpoint columns
	logic signed [CW:0]     dy_c, ady2_c;
	logic [CW:0]            t0_c, t1_c;
	logic [F-1:0]           low0_c, low1_c;
	// divider
	logic                   ge_c;
	logic [RW-1:0]          rsub_c;
	// endpoint y
	logic [CW-1:0]          ybase_c;
	logic signed [SW-1:0]   sum_c;
	logic signed [YW-1:0]   ye_c, ynext_c;
	logic signed [SPW-1:0]  span_c;
	logic [NW-1:0]          ncols_c;
	// output word
	logic signed [IW-1:0]   iy_c;
	logic [PW-1:0]          q_c;
	logic signed [alr_pkg::PIX_W-1:0] cx_c, cy_c;
	logic [alr_pkg::COV_W-1:0] cv_c;

	always_comb begin
		odx_c   = $signed({1'b0, x1_q}) - $signed({1'b0, x0_q});
		ody_c   = $signed({1'b0, y1_q}) - $signed({1'b0, y0_q});
		adx_c   = odx_c[CW] ? -odx_c : odx_c;
		ady_c   = ody_c[CW] ? -ody_c : ody_c;
		steep_c = $unsigned(ady_c) > $unsigned(adx_c);

		dy_c    = ody_c;
		ady2_c  = ady_c;
		t0_c    = {1'b0, x0_q} + (CW + 1)'(HALF);
		t1_c    = {1'b0, x1_q} + (CW + 1)'(HALF);
		low0_c  = t0_c[F-1:0];
		low1_c  = t1_c[F-1:0];

		ge_c    = rem_q >= {1'b0, dx_q};
		rsub_c  = rem_q - (ge_c ? {1'b0, dx_q} : RW'(0));

		ybase_c = cmd.sel_e2 ? y1_q : y0_q;
		sum_c   = $signed({{(SW - CW - S){1'b0}}, ybase_c, {S{1'b0}}}) + SW'(prod_q);
		ye_c    = YW'(sum_c >>> F);
		ynext_c = yacc_q + YW'(grad_q);

		span_c  = $signed({{(SPW - XW){1'b0}}, xe2_q})
			- $signed({{(SPW - XW){1'b0}}, xe1_q}) - SPW'(1);
		if (span_c < 0) begin
			ncols_c = '0;
		end else if (span_c > $signed(SPW'(LIMIT))) begin
			ncols_c = NW'(LIMIT);
		end else begin
			ncols_c = NW'(span_c);
		end

		// lower pixel weight (1 - fr) * gap, upper fr * gap
		iy_c = ycur_q[YW-1:S];
		q_c  = (PW'(xg_q) << S) - p_q;
		cx_c = alr_pkg::PIX_W'(xcur_q);
		if (cmd.emit_hi) begin
			cy_c = alr_pkg::PIX_W'(iy_c) + alr_pkg::PIX_W'(1);
			cv_c = alr_pkg::COV_W'(p_q >> SH);
		end else begin
			cy_c = alr_pkg::PIX_W'(iy_c);
			cv_c = alr_pkg::COV_W'(q_c >> SH);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x0_q <= start_x;
			y0_q <= start_y;
			x1_q <= end_x;
			y1_q <= end_y;
		end
		if (cmd.orient) begin
			steep_q <= steep_c;
			if (steep_c) begin
				x0_q <= y0_q;
				y0_q <= x0_q;
				x1_q <= y1_q;
				y1_q <= x1_q;
			end
		end
		if (cmd.order && (x0_q > x1_q)) begin
			x0_q <= x1_q;
			y0_q <= y1_q;
			x1_q <= x0_q;
			y1_q <= y0_q;
		end
		if (cmd.diff) begin
			dx_q     <= x1_q - x0_q;
			dy_neg_q <= dy_c[CW];
			rem_q    <= RW'($unsigned(ady2_c));
			quo_q    <= '0;
			xe1_q    <= t0_c[CW:F];
			xe2_q    <= t1_c[CW:F];
			d1_q     <= $signed(DW'(HALF)) - $signed({1'b0, low0_c});
			d2_q     <= $signed(DW'(HALF)) - $signed({1'b0, low1_c});
			xg1_q    <= DW'(ONE) - {1'b0, low0_c};
			xg2_q    <= {1'b0, low1_c};
		end
		if (cmd.div_step) begin
			rem_q <= rsub_c << 1;
			quo_q <= {quo_q[QW-2:0], ge_c};
		end
		if (cmd.grad) begin
			if (dx_q == '0) begin
				grad_q <= GW'(1) << S;
			end else if (dy_neg_q) begin
				grad_q <= -$signed({1'b0, quo_q});
			end else begin
				grad_q <= $signed({1'b0, quo_q});
			end
		end
		if (cmd.mul) begin
			prod_q <= grad_q * (cmd.sel_e2 ? d2_q : d1_q);
		end
		if (cmd.sum) begin
			ycur_q <= ye_c;
			if (cmd.sel_e2) begin
				xcur_q <= xe2_q;
				xg_q   <= xg2_q;
				cnt_q  <= ncols_c;
			end else begin
				xcur_q <= xe1_q;
				xg_q   <= xg1_q;
				yacc_q <= ye_c;
				col_q  <= xe1_q;
			end
		end
		if (cmd.step) begin
			yacc_q <= ynext_c;
			ycur_q <= ynext_c;
			col_q  <= col_q + 1'b1;
			xcur_q <= col_q + 1'b1;
			xg_q   <= DW'(ONE);
			cnt_q  <= cnt_q - 1'b1;
		end
		if (cmd.cov) begin
			p_q <= PW'(ycur_q[S-1:0]) * PW'(xg_q);
		end
		if (cmd.emit_lo || cmd.emit_hi) begin
			px_q   <= steep_q ? cy_c : cx_c;
			py_q   <= steep_q ? cx_c : cy_c;
			cov_q  <= cv_c;
			last_q <= cmd.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_lo || cmd.emit_hi) begin
			out_valid_q <= 1'b1;
		end else if (pix_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign status.out_free = !out_valid_q || pix_ready;
	assign status.cnt_zero = (cnt_q == '0);

	assign pix_valid = out_valid_q;
	assign pixel_x   = px_q;
	assign pixel_y   = py_q;
	assign coverage  = cov_q;
	assign last      = last_q;

endmodule

>>> hw/rtl/antialiased_line_rasterizer.sv
`timescale 1ns / 1ps
// antialiased_line_rasterizer: Wu antialiased line segments to pixel words.
// Depends on alr_pkg, alr_ifs (alr_seg_if, alr_pix_if), alr_ctrl, alr_datapath.
//
//  channel   modport  word                                   handshake
//  segment   sink     start_x, start_y, end_x, end_y (Q4.8)  valid/ready
//  pixel     source   pixel_x, pixel_y, coverage, last       valid/ready
//
// Sequence, with n interior columns (0..min(TILE_SIZE-1, 15)) a segment:
//   setup runs the restoring divider, one quotient bit a cycle (17
//   iterations); each endpoint pair then takes the gradient product, y
//   sum, coverage product and two words, and each of the n interior
//   pairs the y step, coverage product and two words.
// Reset: asynchronous; sequencer idle, output register empty.
// Stalls: the sequencer holds in its emit states while the output word waits;
//   a new segment is taken once the last word is loaded, even if not yet read.
module antialiased_line_rasterizer #(
	parameter int unsigned TILE_SIZE = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	alr_seg_if.sink         segment,
	alr_pix_if.source       pixel
);

	// interior columns beyond this are dropped (at most 34 words a segment)
	localparam int unsigned LIMIT = ((TILE_SIZE - 1) < alr_pkg::MAX_COLS)
		? (TILE_SIZE - 1) : alr_pkg::MAX_COLS;

	alr_pkg::alr_cmd_t    cmd;
	alr_pkg::alr_status_t status;

	// sequencer: one segment at a time
	alr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.seg_valid (segment.valid),
		.seg_ready (segment.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// arithmetic and the output word register
	alr_datapath #(
		.LIMIT (LIMIT)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.start_x   (segment.start_x),
		.start_y   (segment.start_y),
		.end_x     (segment.end_x),
		.end_y     (segment.end_y),
		.pix_valid (pixel.valid),
		.pix_ready (pixel.ready),
		.pixel_x   (pixel.pixel_x),
		.pixel_y   (pixel.pixel_y),
		.coverage  (pixel.coverage),
		.last      (pixel.last)
	);

	// at most one datapath operation per cycle
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.orient, cmd.order, cmd.diff, cmd.div_step, cmd.grad,
			cmd.mul, cmd.sum, cmd.cov, cmd.step, cmd.emit_lo, cmd.emit_hi}))
		else $error("more than one datapath operation in a cycle");

	// a word is never loaded over one that is still waiting
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_lo || cmd.emit_hi) |-> status.out_free)
		else $error("output word overwritten");

	// the end flag goes only with the upper word of a pair
	a_last_hi: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.last |-> cmd.emit_hi)
		else $error("last flag outside an upper-pixel word");

	// a taken segment closes the input until its burst is done
	a_seg_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(segment.valid && segment.ready) |=> !segment.ready)
		else $error("segment taken while busy");

endmodule
